@@ design/fsd_pkg.sv @@
// Shared constants and types for the Floyd-Steinberg dither and pack block.
// No dependencies; imported by fsd_diffuse, fsd_pack and the top level.
package fsd_pkg;

	// Defaults of the top-level parameters
	localparam int LINE_DEPTH_DEF    = 512;
	localparam int FRACTION_BITS_DEF = 4;

	// Configuration registers
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;
	localparam int WIDTH_REG_W  = 10;
	localparam int HEIGHT_REG_W = 16;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(384);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(1);

	// Register index, taken from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Position flags of one pixel inside the frame
	typedef struct packed {
		logic first_row;
		logic last_row;
		logic last_col;
	} pix_ctl_t;

endpackage

@@ design/fsd_linebuf.sv @@
// Line buffer holding the diffused error for the next row.
// One write port, one registered read port with write-to-read bypass.
module fsd_linebuf #(
	parameter int DEPTH = 512,
	parameter int DW    = 14
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			// same-edge write of the entry being fetched
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

@@ design/fsd_diffuse.sv @@
// Error diffusion datapath: working value, threshold, 7/3/5/1 split.
// Uses fsd_pkg; feeds fsd_linebuf writes and the bit packer.
module fsd_diffuse
	import fsd_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int CW            = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic                              go,
	input  logic [7:0]                        gray,
	input  logic [CW-1:0]                     col,
	input  pix_ctl_t                          ctl,
	input  logic signed [FRACTION_BITS+9:0]   line_err,
	output logic                              black,
	output logic                              wr_en,
	output logic [CW-1:0]                     wr_addr,
	output logic signed [FRACTION_BITS+9:0]   wr_data
);

	localparam int EB = FRACTION_BITS + 10;
	localparam int AW = EB + 4;
	localparam logic signed [AW-1:0] EMAX = AW'((1 << (EB - 1)) - 1);
	localparam logic signed [AW-1:0] EMIN = -EMAX - AW'(1);
	localparam logic signed [AW-1:0] HALF = AW'(255 << (FRACTION_BITS - 1));
	localparam logic signed [AW-1:0] FULL = AW'(255 << FRACTION_BITS);

	function automatic logic signed [AW-1:0] ext_f(input logic signed [EB-1:0] e);
		ext_f = {{(AW-EB){e[EB-1]}}, e};
	endfunction

	function automatic logic signed [EB-1:0] sat_f(input logic signed [AW-1:0] a);
		if (a > EMAX) begin
			sat_f = EMAX[EB-1:0];
		end else if (a < EMIN) begin
			sat_f = EMIN[EB-1:0];
		end else begin
			sat_f = a[EB-1:0];
		end
	endfunction

	logic signed [EB-1:0] rc_q, bp_q, br_q, edge_q;
	logic signed [AW-1:0] pix_w, line_w, v_w, vs_w, err_w;
	logic signed [AW-1:0] e3_w, e5_w, e7_w, f1_w, f3_w, f5_w, f7_w;
	logic signed [EB-1:0] v_sat, cur_err;

	assign pix_w  = {{(AW-8-FRACTION_BITS){1'b0}}, gray, {FRACTION_BITS{1'b0}}};
	// last column reads the edge register, first row reads nothing
	assign line_w = ctl.first_row ? '0 : ext_f(ctl.last_col ? edge_q : line_err);
	assign v_w    = pix_w + ext_f(rc_q) + line_w;
	assign v_sat  = sat_f(v_w);
	assign vs_w   = ext_f(v_sat);
	assign black  = !(vs_w > HALF);
	assign err_w  = black ? vs_w : vs_w - FULL;

	assign e3_w = (err_w <<< 1) + err_w;
	assign e5_w = (err_w <<< 2) + err_w;
	assign e7_w = (err_w <<< 3) - err_w;
	assign f1_w = err_w >>> 4;
	assign f3_w = e3_w >>> 4;
	assign f5_w = e5_w >>> 4;
	assign f7_w = e7_w >>> 4;

	assign cur_err = sat_f(ext_f(br_q) + f5_w);

	assign wr_en   = go && !ctl.last_row && (col != '0);
	assign wr_addr = col - CW'(1);
	assign wr_data = sat_f(ext_f(bp_q) + f3_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			bp_q <= '0;
			br_q <= '0;
		end else if (restart) begin
			rc_q <= '0;
			bp_q <= '0;
			br_q <= '0;
		end else if (go) begin
			rc_q <= ctl.last_col ? '0 : sat_f(f7_w);
			if (ctl.last_row || ctl.last_col) begin
				bp_q <= '0;
				br_q <= '0;
			end else begin
				bp_q <= cur_err;
				br_q <= sat_f(f1_w);
			end
		end
	end

	// entry of the last column lives here, not in the line buffer
	always_ff @(posedge clk) begin
		if (go && ctl.last_col && !ctl.last_row) begin
			edge_q <= cur_err;
		end
	end

endmodule

@@ design/fsd_pack.sv @@
// Bit packer and output register: eight pixels per byte, MSB first.
// Uses fsd_pkg for the pixel position flags.
module fsd_pack
	import fsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       restart,
	input  logic       go,
	input  logic       black,
	input  pix_ctl_t   ctl,
	input  logic       byte_stall,
	output logic       byte_valid,
	output logic [7:0] packed_bits,
	output logic       row_done,
	output logic       frame_done
);

	logic [7:0] shift_q, shift_nxt;
	logic [2:0] fill_q;
	logic       emit;
	logic       ov_q;
	logic [7:0] bits_q;
	logic       row_q, frame_q;

	assign shift_nxt = shift_q | ({black, 7'b0} >> fill_q);
	assign emit      = (fill_q == 3'd7) || ctl.last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			fill_q  <= '0;
			ov_q    <= 1'b0;
		end else if (restart) begin
			shift_q <= '0;
			fill_q  <= '0;
		end else begin
			if (go) begin
				if (emit) begin
					shift_q <= '0;
					fill_q  <= '0;
				end else begin
					shift_q <= shift_nxt;
					fill_q  <= fill_q + 3'd1;
				end
			end
			if (go && emit) begin
				ov_q <= 1'b1;
			end else if (!byte_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			bits_q  <= shift_nxt;
			row_q   <= ctl.last_col;
			frame_q <= ctl.last_col && ctl.last_row;
		end
	end

	assign byte_valid  = ov_q;
	assign packed_bits = bits_q;
	assign row_done    = row_q;
	assign frame_done  = frame_q;

endmodule

@@ design/floyd_steinberg_dither_pack_core.sv @@
// Top level of the Floyd-Steinberg dither and 1-bit pack block.
// Depends on fsd_pkg, fsd_linebuf, fsd_diffuse and fsd_pack.
//
// Usage:
//  - Pixel channel (pixel_valid / pixel_stall / gray_level): 8-bit gray
//    pixels in raster order, one item per cycle while pixel_stall is low.
//  - Byte channel (byte_valid / byte_stall / packed_bits, row_done,
//    frame_done): one item per eight pixels, plus a zero-padded partial
//    byte at each row end. 1 = black, leftmost pixel in the MSB.
//  - APB port: reg 0 (addr 0) image_width, reg 1 (addr 4) image_height.
//    Any write restarts the frame; write only while the block is idle.
//  - Timing: a pixel is registered at acceptance while its line-buffer
//    entry is fetched; when the pixel stage advances, the diffusion logic
//    runs and the byte, if completed, lands in the output register that
//    drives byte_valid. Throughput is 1 pixel per cycle unless a stalled
//    byte holds the stage; the line-buffer read is issued one pixel ahead.
//  - Stall: a stalled byte holds; the pixel stage behind it fills and
//    pixel_stall rises only when both are occupied.
//  - Reset: width 384, height 1, counters, carries and packer cleared.
//    The line buffer is not cleared; the first row of a frame never reads it.
module floyd_steinberg_dither_pack_core
	import fsd_pkg::*;
#(
	parameter int LINE_DEPTH    = LINE_DEPTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// pixel channel
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  logic [7:0]         gray_level,
	// byte channel
	output logic               byte_valid,
	input  logic               byte_stall,
	output logic [7:0]         packed_bits,
	output logic               row_done,
	output logic               frame_done,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int CW   = $clog2(LINE_DEPTH);
	localparam int CMPW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
	localparam int EB   = FRACTION_BITS + 10;

	// ---------------- configuration ----------------
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	// Effective frame size: zero acts as one, width clamps to the buffer.
	logic [CMPW-1:0]         w_ext, w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;

	assign w_ext = CMPW'(width_q);
	assign w_eff = (w_ext == '0) ? CMPW'(1) :
	               (w_ext > CMPW'(LINE_DEPTH)) ? CMPW'(LINE_DEPTH) : w_ext;
	assign h_eff = (height_q == '0) ? HEIGHT_REG_W'(1) : height_q;

	// ---------------- position counters (front of pipe) ----------------
	logic [CW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	pix_ctl_t                ctl_in;
	logic                    pix_acc;

	assign pix_acc          = pixel_valid && !pixel_stall;
	assign ctl_in.last_col  = (CMPW'(CMPW'(col_q) + CMPW'(1)) == w_eff);
	assign ctl_in.last_row  = (row_q == h_eff - HEIGHT_REG_W'(1));
	assign ctl_in.first_row = (row_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (ctl_in.last_col) begin
				col_q <= '0;
				row_q <= ctl_in.last_row ? '0 : row_q + HEIGHT_REG_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- pixel stage ----------------
	logic           s1_v_q;
	logic [7:0]     gray_s1;
	logic [CW-1:0]  col_s1;
	pix_ctl_t       ctl_s1;
	logic           s1_go;

	// stage advances unless a finished byte is still waiting
	assign s1_go       = s1_v_q && (!byte_valid || !byte_stall);
	assign pixel_stall = s1_v_q && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (pix_acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_go) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			gray_s1 <= gray_level;
			col_s1  <= col_q;
			ctl_s1  <= ctl_in;
		end
	end

	// ---------------- line buffer ----------------
	logic                 lb_wr_en;
	logic [CW-1:0]        lb_wr_addr;
	logic signed [EB-1:0] lb_wr_data;
	logic [EB-1:0]        lb_rd_data;

	fsd_linebuf #(
		.DEPTH (LINE_DEPTH),
		.DW    (EB)
	) u_linebuf (
		.clk     (clk),
		.wr_en   (lb_wr_en),
		.wr_addr (lb_wr_addr),
		.wr_data (lb_wr_data),
		.rd_en   (pix_acc),
		.rd_addr (col_q),
		.rd_data (lb_rd_data)
	);

	// ---------------- diffusion datapath ----------------
	logic black;

	fsd_diffuse #(
		.FRACTION_BITS (FRACTION_BITS),
		.CW            (CW)
	) u_diffuse (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_wr),
		.go       (s1_go),
		.gray     (gray_s1),
		.col      (col_s1),
		.ctl      (ctl_s1),
		.line_err (signed'(lb_rd_data)),
		.black    (black),
		.wr_en    (lb_wr_en),
		.wr_addr  (lb_wr_addr),
		.wr_data  (lb_wr_data)
	);

	// ---------------- packer and output register ----------------
	fsd_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (cfg_wr),
		.go          (s1_go),
		.black       (black),
		.ctl         (ctl_s1),
		.byte_stall  (byte_stall),
		.byte_valid  (byte_valid),
		.packed_bits (packed_bits),
		.row_done    (row_done),
		.frame_done  (frame_done)
	);

endmodule

@@ design/fsd_checker.sv @@
// Port-level checks for floyd_steinberg_dither_pack_core.
// Uses only top-level ports; attached by the bind at the end of this file.
module fsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_valid,
	input logic       pixel_stall,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] packed_bits,
	input logic       row_done,
	input logic       frame_done
);

	// frame end is always a row end
	a_frame_is_row: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid |-> (!frame_done || row_done))
		else $error("frame_done without row_done");

	// a new byte follows an accepted pixel
	a_byte_from_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byte_valid) |-> $past(pixel_valid && !pixel_stall, 2))
		else $error("byte appeared without a preceding pixel");

	// input backs up only behind a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (byte_valid && byte_stall))
		else $error("pixel_stall without a stalled byte");

	// stalled byte holds
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && byte_stall) |=>
			(byte_valid && $stable(packed_bits) && $stable(row_done) &&
			 $stable(frame_done)))
		else $error("stalled byte changed");

endmodule

bind floyd_steinberg_dither_pack_core fsd_checker u_fsd_checker (.*);
